@@ design/clws_pkg.sv @@
package clws_pkg;

  // Command codes on the request channel
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_ADDR  = 3'd2;
  localparam logic [2:0] CMD_RC    = 3'd3;
  localparam logic [2:0] CMD_DIGIT = 3'd4;
  localparam logic [2:0] CMD_SIGN  = 3'd5;
  localparam logic [2:0] CMD_BLANK = 3'd6;

  // Status codes on the result channel
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ROW   = 3'd1;
  localparam logic [2:0] ST_BAD_COL   = 3'd2;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ST_BAD_SIGN  = 3'd4;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd62;

  localparam logic [7:0] SET_DDRAM  = 8'h80;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] INS_CLEAR  = 8'h01;

  localparam int unsigned INIT_LEN = 9;
  localparam logic [3:0] INIT_LAST_IDX = 4'(INIT_LEN - 1);
  localparam logic [17:0] INIT_FIRST_PAUSE = 18'd40000;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_SINGLE,
    JOB_PAIR
  } job_kind_t;

  typedef struct packed {
    logic       valid;
    job_kind_t  kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [2:0] status;
    logic       sends;
  } job_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h38;
      4'd1:    b = 8'h39;
      4'd2:    b = 8'h14;
      4'd3:    b = 8'h78;
      4'd4:    b = 8'h56;
      4'd5:    b = 8'h6C;
      4'd6:    b = 8'h38;
      4'd7:    b = 8'h0C;
      4'd8:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [17:0] init_after(input logic [3:0] idx);
    logic [17:0] p;
    case (idx)
      4'd5:    p = 18'd200000;
      4'd8:    p = 18'd2000;
      default: p = 18'd27;
    endcase
    return p;
  endfunction

endpackage

@@ design/char_lcd_write_sequencer.sv @@
// Character-LCD write sequencer.
//
// Request channel (in_valid / in_stall): one word per display request,
// fields command, char_value, ddram_address, row, column. A request is
// taken at a rising edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall): one word per bus write, or one
// error word for a bad request; last marks the final word of a request.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the 7-bit
// device address; cfg_ready is always high. Write it only while idle.
//
// A request is loaded into the job register; its words then leave the
// output register one per cycle while out_stall is low. Char requests
// have 2 words each, clear requests and errors 1, init requests 9;
// the emit counter over the job register sets this. The next request is
// taken in the cycle the current job's last word loads, so runs follow
// with no gap. Unused command code 7 is taken and produces no words.
// A stalled result holds; the job then holds too and in_stall rises.
// Reset (rst, synchronous) empties both stages and sets address 62.
module char_lcd_write_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  char_value,
  input  logic [6:0]  ddram_address,
  input  logic [7:0]  row,
  input  logic [7:0]  column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  bus_address,
  output logic        is_data,
  output logic [7:0]  payload,
  output logic [17:0] pause_before_us,
  output logic [17:0] pause_after_us,
  output logic [2:0]  status,
  output logic        sends,
  output logic        last
);

  logic [6:0]     device_address;
  clws_pkg::job_t dec;
  clws_pkg::job_t job;
  logic [3:0]     idx;

  logic advance;
  logic last_idx;
  logic done;
  logic accept;

  logic        is_data_next;
  logic [7:0]  payload_next;
  logic [17:0] before_next;
  logic [17:0] after_next;

  clws_decode u_decode (
    .command       (command),
    .char_value    (char_value),
    .ddram_address (ddram_address),
    .row           (row),
    .column        (column),
    .job           (dec)
  );

  assign cfg_ready = 1'b1;

  // Advance the job whenever the output register is free or draining
  assign advance = job.valid && (!out_valid || !out_stall);

  always_comb begin
    case (job.kind)
      clws_pkg::JOB_INIT: last_idx = (idx == clws_pkg::INIT_LAST_IDX);
      clws_pkg::JOB_PAIR: last_idx = (idx == 4'd1);
      default:            last_idx = 1'b1;
    endcase
  end

  assign done     = advance && last_idx;
  assign in_stall = job.valid && !done;
  assign accept   = in_valid && !in_stall;

  // Build the word for the current emit index
  always_comb begin
    is_data_next = 1'b0;
    payload_next = job.byte0;
    before_next  = 18'd0;
    after_next   = 18'd0;
    case (job.kind)
      clws_pkg::JOB_INIT: begin
        payload_next = clws_pkg::init_byte(idx);
        before_next  = (idx == 4'd0) ? clws_pkg::INIT_FIRST_PAUSE : 18'd0;
        after_next   = clws_pkg::init_after(idx);
      end
      clws_pkg::JOB_PAIR: begin
        if (idx != 4'd0) begin
          is_data_next = 1'b1;
          payload_next = job.byte1;
        end
      end
      default: payload_next = job.byte0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= clws_pkg::DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_address <= cfg_data;
    end
  end

  // Job register: load on accept, step the index per emitted word
  always_ff @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
      idx       <= 4'd0;
    end else if (accept) begin
      job <= dec;
      idx <= 4'd0;
    end else if (done) begin
      job.valid <= 1'b0;
    end else if (advance) begin
      idx <= idx + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bus_address     <= job.sends ? device_address : 7'd0;
      is_data         <= is_data_next;
      payload         <= payload_next;
      pause_before_us <= before_next;
      pause_after_us  <= after_next;
      status          <= job.status;
      sends           <= job.sends;
      last            <= last_idx;
    end
  end

endmodule

@@ design/clws_decode.sv @@
module clws_decode (
  input  logic [2:0]    command,
  input  logic [7:0]    char_value,
  input  logic [6:0]    ddram_address,
  input  logic [7:0]    row,
  input  logic [7:0]    column,
  output clws_pkg::job_t job
);

  logic [7:0] ch;
  logic [2:0] pre_err;
  logic [2:0] err;
  logic [7:0] rc_addr;

  // Character byte and digit/sign check for the row/column commands
  always_comb begin
    ch      = char_value;
    pre_err = clws_pkg::ST_OK;
    case (command)
      clws_pkg::CMD_DIGIT: begin
        ch = clws_pkg::DIGIT_BASE | {4'd0, char_value[3:0]};
        if (char_value > 8'd9) pre_err = clws_pkg::ST_BAD_DIGIT;
      end
      clws_pkg::CMD_SIGN: begin
        if (char_value != clws_pkg::CHAR_PLUS && char_value != clws_pkg::CHAR_MINUS)
          pre_err = clws_pkg::ST_BAD_SIGN;
      end
      clws_pkg::CMD_BLANK: ch = clws_pkg::CHAR_SPACE;
      default: ch = char_value;
    endcase
  end

  always_comb begin
    if (pre_err != clws_pkg::ST_OK)  err = pre_err;
    else if (row > 8'd1)             err = clws_pkg::ST_BAD_ROW;
    else if (column > 8'd15)         err = clws_pkg::ST_BAD_COL;
    else                             err = clws_pkg::ST_OK;
  end

  // 0x80 | (0x40*row + col), valid only for row <= 1 and col <= 15
  assign rc_addr = {1'b1, row[0], 2'b00, column[3:0]};

  always_comb begin
    job.valid  = 1'b1;
    job.kind   = clws_pkg::JOB_SINGLE;
    job.byte0  = 8'h00;
    job.byte1  = ch;
    job.status = clws_pkg::ST_OK;
    job.sends  = 1'b1;
    case (command)
      clws_pkg::CMD_INIT:  job.kind = clws_pkg::JOB_INIT;
      clws_pkg::CMD_CLEAR: job.byte0 = clws_pkg::INS_CLEAR;
      clws_pkg::CMD_ADDR: begin
        job.kind  = clws_pkg::JOB_PAIR;
        job.byte0 = clws_pkg::SET_DDRAM | {1'b0, ddram_address};
        job.byte1 = char_value;
      end
      clws_pkg::CMD_RC, clws_pkg::CMD_DIGIT, clws_pkg::CMD_SIGN, clws_pkg::CMD_BLANK: begin
        if (err != clws_pkg::ST_OK) begin
          job.status = err;
          job.sends  = 1'b0;
        end else begin
          job.kind  = clws_pkg::JOB_PAIR;
          job.byte0 = rc_addr;
        end
      end
      default: job.valid = 1'b0;  // drop the unused code
    endcase
  end

endmodule

@@ design/clws_checker.sv @@
module clws_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  bus_address,
  input logic        is_data,
  input logic [7:0]  payload,
  input logic [2:0]  status,
  input logic        sends,
  input logic        last
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload) && $stable(last))
    else $error("stalled result word changed");

  // Error words end their run and carry an error code
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sends |-> last && status != clws_pkg::ST_OK)
    else $error("error word not final or without code");

  // Error words carry no write content
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sends |-> bus_address == 7'd0 && payload == 8'd0 && !is_data)
    else $error("error word carries write fields");

  // A data write always closes its run
  a_data_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_data |-> last && sends)
    else $error("data write not final");

endmodule

bind char_lcd_write_sequencer clws_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bus_address (bus_address),
  .is_data     (is_data),
  .payload     (payload),
  .status      (status),
  .sends       (sends),
  .last        (last)
);

@@ tb/char_lcd_write_sequencer_tb.sv @@
`timescale 1ns / 1ps

module char_lcd_write_sequencer_tb;

  // Command code 7 has no name in the package; the block takes it and drops it.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  // Cycles to let pass after the last expected word before a register write
  // or the final verdict; covers a dropped request still in the job stage.
  localparam int TAIL_CYCLES  = 6;
  // Long receiver hold-off that backs up the pipe into in_stall.
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 37;
  // Limit on the whole run before it is taken as hung.
  localparam int CYCLE_LIMIT  = 200000;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [6:0]  bus_address;
    logic        is_data;
    logic [7:0]  payload;
    logic [17:0] pause_before_us;
    logic [17:0] pause_after_us;
    logic [2:0]  status;
    logic        sends;
    logic        last;
  } lcd_write_t;

  // Predicts the bus writes of each accepted request and checks the words
  // that come out against them, oldest first.
  class lcd_write_ledger;
    lcd_write_t  pending_writes[$];
    logic [6:0]  dev_addr;
    logic [7:0]  init_seq[9];
    logic [17:0] init_wait[9];
    int unsigned mismatches;

    function new();
      dev_addr   = clws_pkg::DEV_ADDR_RESET;
      mismatches = 0;
      init_seq   = '{8'h38, 8'h39, 8'h14, 8'h78, 8'h56, 8'h6C, 8'h38, 8'h0C, 8'h01};
      init_wait  = '{18'd27, 18'd27, 18'd27, 18'd27, 18'd27, 18'd200000,
                     18'd27, 18'd27, 18'd2000};
    endfunction

    function void set_address(logic [6:0] value);
      dev_addr = value;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void push_write(logic data, logic [7:0] pay, logic [17:0] wait_pre,
                             logic [17:0] wait_post, logic fin);
      lcd_write_t w;
      w.bus_address     = dev_addr;
      w.is_data         = data;
      w.payload         = pay;
      w.pause_before_us = wait_pre;
      w.pause_after_us  = wait_post;
      w.status          = clws_pkg::ST_OK;
      w.sends           = 1'b1;
      w.last            = fin;
      pending_writes.push_back(w);
    endfunction

    function void push_error(logic [2:0] code);
      lcd_write_t w;
      w        = '0;
      w.status = code;
      w.last   = 1'b1;
      pending_writes.push_back(w);
    endfunction

    // Set-DDRAM instruction, then the character as data.
    function void push_char(logic [6:0] addr, logic [7:0] ch);
      push_write(1'b0, clws_pkg::SET_DDRAM | {1'b0, addr}, '0, '0, 1'b0);
      push_write(1'b1, ch, '0, '0, 1'b1);
    endfunction

    function void push_char_rc(logic [7:0] ch, logic [7:0] r, logic [7:0] c);
      logic [6:0] addr;
      addr = 7'(r) * 7'd64 + 7'(c);
      if (r > 8'd1)
        push_error(clws_pkg::ST_BAD_ROW);
      else if (c > 8'd15)
        push_error(clws_pkg::ST_BAD_COL);
      else
        push_char(addr, ch);
    endfunction

    function void take_request(logic [2:0] cmd, logic [7:0] ch, logic [6:0] addr,
                               logic [7:0] r, logic [7:0] c);
      int i;
      case (cmd)
        clws_pkg::CMD_INIT: begin
          for (i = 0; i < 9; i++)
            push_write(1'b0, init_seq[i],
                       (i == 0) ? clws_pkg::INIT_FIRST_PAUSE : 18'd0,
                       init_wait[i], i == 8);
        end
        clws_pkg::CMD_CLEAR: push_write(1'b0, clws_pkg::INS_CLEAR, '0, '0, 1'b1);
        clws_pkg::CMD_ADDR:  push_char(addr, ch);
        clws_pkg::CMD_RC:    push_char_rc(ch, r, c);
        clws_pkg::CMD_DIGIT: begin
          if (ch > 8'd9)
            push_error(clws_pkg::ST_BAD_DIGIT);
          else
            push_char_rc(clws_pkg::DIGIT_BASE | ch, r, c);
        end
        clws_pkg::CMD_SIGN: begin
          if (ch != clws_pkg::CHAR_PLUS && ch != clws_pkg::CHAR_MINUS)
            push_error(clws_pkg::ST_BAD_SIGN);
          else
            push_char_rc(ch, r, c);
        end
        clws_pkg::CMD_BLANK: push_char_rc(clws_pkg::CHAR_SPACE, r, c);
        default: ;
      endcase
    endfunction

    function void field_diff(string name, logic [17:0] want, logic [17:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(lcd_write_t got);
      lcd_write_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual payload %0d status %0d",
                 $time, got.payload, got.status);
        mismatches++;
        return;
      end
      want = pending_writes.pop_front();
      field_diff("bus_address", 18'(want.bus_address), 18'(got.bus_address));
      field_diff("is_data", 18'(want.is_data), 18'(got.is_data));
      field_diff("payload", 18'(want.payload), 18'(got.payload));
      field_diff("pause_before_us", want.pause_before_us, got.pause_before_us);
      field_diff("pause_after_us", want.pause_after_us, got.pause_after_us);
      field_diff("status", 18'(want.status), 18'(got.status));
      field_diff("sends", 18'(want.sends), 18'(got.sends));
      field_diff("last", 18'(want.last), 18'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [7:0]  char_value;
  logic [6:0]  ddram_address;
  logic [7:0]  row;
  logic [7:0]  column;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  bus_address;
  logic        is_data;
  logic [7:0]  payload;
  logic [17:0] pause_before_us;
  logic [17:0] pause_after_us;
  logic [2:0]  status;
  logic        sends;
  logic        last;

  // Idle odds in percent: the sender's gaps and the receiver's stalls.
  int   gap_pct   = 30;
  int   stall_pct = 73;
  logic pressure_on   = 1'b0;
  logic pressure_done = 1'b0;
  int   cycle_count   = 0;

  lcd_write_ledger ledger = new();

  char_lcd_write_sequencer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .char_value      (char_value),
    .ddram_address   (ddram_address),
    .row             (row),
    .column          (column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .bus_address     (bus_address),
    .is_data         (is_data),
    .payload         (payload),
    .pause_before_us (pause_before_us),
    .pause_after_us  (pause_after_us),
    .status          (status),
    .sends           (sends),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_write_sequencer verification failed");
      $finish;
    end
  end

  // Receiver: stall at random, except for one long hold-off counted here
  // while the sender keeps offering requests.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        pressure_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Take every word that leaves the block; values seen here are the ones
  // that stood before the edge.
  always @(posedge clk) begin : watch_words
    lcd_write_t got;
    if (!rst && out_valid && !out_stall) begin
      got.bus_address     = bus_address;
      got.is_data         = is_data;
      got.payload         = payload;
      got.pause_before_us = pause_before_us;
      got.pause_after_us  = pause_after_us;
      got.status          = status;
      got.sends           = sends;
      got.last            = last;
      ledger.check_write(got);
    end
  end

  // Offer one request word, idling first at random, and hold it until it
  // is taken; then log it with the ledger.
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] ch,
                              input logic [6:0] addr, input logic [7:0] r,
                              input logic [7:0] c);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    char_value    <= ch;
    ddram_address <= addr;
    row           <= r;
    column        <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.take_request(cmd, ch, addr, r, c);
  endtask

  // Build a mostly well-formed request with random content; a share of
  // them carry bad rows, columns, digits or signs, or the unused code.
  task automatic random_request(output bit dropped);
    int         pick;
    logic [2:0] cmd;
    logic [7:0] ch;
    logic [7:0] r;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      cmd = CMD_UNUSED;
    else if (pick < 10)
      cmd = clws_pkg::CMD_INIT;
    else
      cmd = 3'($urandom_range(clws_pkg::CMD_CLEAR, clws_pkg::CMD_BLANK));
    r = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
    c = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    ch = 8'($urandom_range(0, 255));
    if (cmd == clws_pkg::CMD_DIGIT && $urandom_range(0, 99) < 85)
      ch = 8'($urandom_range(0, 9));
    if (cmd == clws_pkg::CMD_SIGN && $urandom_range(0, 99) < 85)
      ch = $urandom_range(0, 1) ? clws_pkg::CHAR_PLUS : clws_pkg::CHAR_MINUS;
    send_request(cmd, ch, 7'($urandom_range(0, 127)), r, c);
    dropped = (cmd == CMD_UNUSED);
  endtask

  task automatic random_phase();
    int n;
    bit dropped;
    n = 0;
    while (n < PHASE_ITEMS) begin
      random_request(dropped);
      if (!dropped) n++;
    end
  endtask

  // Wait out every expected word, then the tail for a dropped request.
  task automatic drain();
    while (ledger.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ledger.set_address(value);
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    command       <= clws_pkg::CMD_INIT;
    char_value    <= '0;
    ddram_address <= '0;
    row           <= '0;
    column        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset address: every command, field extremes,
    // each error but the bad sign alone, and in the order the checks are made.
    send_request(clws_pkg::CMD_INIT,  8'd0,   7'd0,   8'd0,   8'd0);
    send_request(clws_pkg::CMD_CLEAR, 8'd255, 7'd127, 8'd255, 8'd255);
    send_request(clws_pkg::CMD_ADDR,  8'd0,   7'd0,   8'd0,   8'd0);
    send_request(clws_pkg::CMD_ADDR,  8'd255, 7'd127, 8'd255, 8'd255);
    send_request(clws_pkg::CMD_RC,    8'h41,  7'd0,   8'd0,   8'd0);
    send_request(clws_pkg::CMD_RC,    8'd255, 7'd0,   8'd1,   8'd15);
    send_request(clws_pkg::CMD_RC,    8'h41,  7'd0,   8'd2,   8'd0);
    send_request(clws_pkg::CMD_RC,    8'h41,  7'd0,   8'd255, 8'd255);
    send_request(clws_pkg::CMD_RC,    8'h41,  7'd0,   8'd0,   8'd16);
    send_request(clws_pkg::CMD_DIGIT, 8'd0,   7'd0,   8'd1,   8'd3);
    send_request(clws_pkg::CMD_DIGIT, 8'd9,   7'd0,   8'd0,   8'd15);
    send_request(clws_pkg::CMD_DIGIT, 8'd10,  7'd0,   8'd7,   8'd200);
    send_request(clws_pkg::CMD_DIGIT, 8'd255, 7'd0,   8'd0,   8'd0);
    send_request(clws_pkg::CMD_DIGIT, 8'd5,   7'd0,   8'd1,   8'd99);
    send_request(clws_pkg::CMD_SIGN,  clws_pkg::CHAR_PLUS,  7'd0, 8'd0, 8'd0);
    send_request(clws_pkg::CMD_SIGN,  clws_pkg::CHAR_MINUS, 7'd0, 8'd1, 8'd15);
    send_request(clws_pkg::CMD_SIGN,  8'h2C,  7'd0,   8'd9,   8'd99);
    send_request(clws_pkg::CMD_SIGN,  clws_pkg::CHAR_PLUS,  7'd0, 8'd3, 8'd0);
    send_request(clws_pkg::CMD_BLANK, 8'd0,   7'd0,   8'd1,   8'd15);
    send_request(clws_pkg::CMD_BLANK, 8'd0,   7'd0,   8'd0,   8'd255);
    send_request(CMD_UNUSED,          8'd255, 7'd127, 8'd255, 8'd255);
    send_request(clws_pkg::CMD_CLEAR, 8'd0,   7'd0,   8'd0,   8'd0);
    in_valid <= 1'b0;
    drain();

    // Lowest address; sender gaps sparse, receiver stalls often.
    write_address(7'd0);
    random_phase();
    in_valid <= 1'b0;
    drain();

    // Highest address; swap the idle odds.
    write_address(7'd127);
    gap_pct   = 73;
    stall_pct <= 30;
    random_phase();
    in_valid <= 1'b0;
    drain();

    // Random address, no idling, and one long receiver hold-off so the
    // block fills and stalls its input.
    write_address(7'($urandom_range(1, 126)));
    gap_pct     = 0;
    stall_pct   <= 0;
    pressure_on <= 1'b1;
    random_phase();
    in_valid <= 1'b0;
    drain();

    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("char_lcd_write_sequencer verification clean");
    else
      $display("char_lcd_write_sequencer verification failed");
    $finish;
  end

endmodule

@@ char_lcd_write_sequencer.f @@
design/clws_pkg.sv
design/clws_decode.sv
design/char_lcd_write_sequencer.sv
design/clws_checker.sv
tb/char_lcd_write_sequencer_tb.sv
